@@ rtl/bad_sector_run_remapper_defines.svh @@
// ----------------------------------------------------------------------------
// Bad-sector run remapper: assertion macros
// Shared helpers for the concurrent checks of the remapper, all clocked on
// clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BAD_SECTOR_RUN_REMAPPER_DEFINES_SVH
`define BAD_SECTOR_RUN_REMAPPER_DEFINES_SVH

// Same-cycle implication
`define BSRR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define BSRR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/bsrr_pkg.sv @@
// ----------------------------------------------------------------------------
// Bad-sector run remapper package
// Command codes, queued operation, table entry and sequencer state types.
// ----------------------------------------------------------------------------
package bsrr_pkg;

  localparam int SECTOR_W = 32;
  localparam int COUNT_W  = 7;
  localparam int Q_DEPTH  = 2;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_REMAP  = 2'd2
  } cmd_t;

  // One classified item as it travels from front to back
  typedef struct packed {
    cmd_t                cmd;
    logic [SECTOR_W-1:0] start_sector;
    logic [COUNT_W-1:0]  sector_count;
    logic [SECTOR_W-1:0] bad_first;
    logic [SECTOR_W-1:0] bad_end;
    logic [SECTOR_W-1:0] alt_first;
  } op_t;

  // One bad-range table entry
  typedef struct packed {
    logic [SECTOR_W-1:0] bad_first;
    logic [SECTOR_W-1:0] bad_end;
    logic [SECTOR_W-1:0] alt_first;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_TAIL
  } back_state_t;

endpackage

@@ rtl/bsrr_front.sv @@
// ----------------------------------------------------------------------------
// Bad-sector run remapper front end
// Accepts input items, drops the unused command code, clamps the request
// length and hands the classified operation to the queue.
// ----------------------------------------------------------------------------
module bsrr_front #(
  parameter int MAX_REQUEST = 64
) (
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_cmd,
  input  logic [bsrr_pkg::SECTOR_W-1:0] in_start_sector,
  input  logic [bsrr_pkg::COUNT_W-1:0]  in_sector_count,
  input  logic [bsrr_pkg::SECTOR_W-1:0] in_entry_bad_start,
  input  logic [bsrr_pkg::SECTOR_W-1:0] in_entry_bad_end,
  input  logic [bsrr_pkg::SECTOR_W-1:0] in_entry_good_start,
  output logic                          push,
  output bsrr_pkg::op_t                 push_op,
  input  logic                          q_room
);
  import bsrr_pkg::*;

  logic known_cmd;

  // Classify the command; the unused code is taken and discarded
  always_comb begin
    case (in_cmd)
      CMD_CLEAR, CMD_APPEND, CMD_REMAP: known_cmd = 1'b1;
      default:                          known_cmd = 1'b0;
    endcase
  end

  assign in_ready = q_room;
  assign push     = in_valid && q_room && known_cmd;

  // Pack the operation, saturating oversize requests
  always_comb begin
    push_op.cmd          = cmd_t'(in_cmd);
    push_op.start_sector = in_start_sector;
    push_op.sector_count = (in_sector_count > COUNT_W'(MAX_REQUEST)) ?
                           COUNT_W'(MAX_REQUEST) : in_sector_count;
    push_op.bad_first    = in_entry_bad_start;
    push_op.bad_end      = in_entry_bad_end;
    push_op.alt_first    = in_entry_good_start;
  end

endmodule

@@ rtl/bsrr_queue.sv @@
// ----------------------------------------------------------------------------
// Bad-sector run remapper operation queue
// Short FIFO between front and back so each side stalls on its own.
// ----------------------------------------------------------------------------
module bsrr_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bsrr_pkg::op_t push_op,
  output logic          q_room,
  output logic          q_valid,
  output bsrr_pkg::op_t q_op,
  input  logic          pop
);
  import bsrr_pkg::*;

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int FILL_W = $clog2(Q_DEPTH + 1);

  op_t               slot_r [Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;

  assign q_room  = (fill_r != FILL_W'(Q_DEPTH));
  assign q_valid = (fill_r != '0);
  assign q_op    = slot_r[rd_ptr_r];

  // Pointer and fill update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   fill_nxt = fill_r + 1'b1;
      2'b01:   fill_nxt = fill_r - 1'b1;
      default: fill_nxt = fill_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Slot storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

@@ rtl/bsrr_back.sv @@
// ----------------------------------------------------------------------------
// Bad-sector run remapper back end
// Owns the bad-range table and entry count, executes clear and append, and
// walks the table one entry at a time to split a request into runs.
// ----------------------------------------------------------------------------
module bsrr_back #(
  parameter int TABLE_ENTRIES = 64,
  parameter int CNT_W         = 7
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  bsrr_pkg::op_t                 q_op,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bsrr_pkg::SECTOR_W-1:0] out_run_sector,
  output logic [bsrr_pkg::COUNT_W-1:0]  out_run_count,
  output logic                          out_remapped,
  output logic                          out_last_run,
  output logic                          out_status,
  output logic [CNT_W-1:0]              entry_cnt
);
  import bsrr_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  // Table memory and registered read port
  entry_t table_mem [TABLE_ENTRIES];
  entry_t rd_q;

  back_state_t          state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic [SECTOR_W:0]    pos_r, pos_nxt;
  logic [COUNT_W-1:0]   left_r, left_nxt;
  logic                 wr_en;

  logic                 out_valid_r;
  logic [SECTOR_W-1:0]  out_sector_r;
  logic [COUNT_W-1:0]   out_count_r;
  logic                 out_remap_r;
  logic                 out_last_r;
  logic                 out_status_r;

  logic                 emit;
  logic [SECTOR_W-1:0]  em_sector;
  logic [COUNT_W-1:0]   em_count;
  logic                 em_remap;
  logic                 em_last;
  logic                 em_status;
  logic                 out_free;

  // Entry evaluation terms
  logic [SECTOR_W:0]    bs33, be33;
  logic [SECTOR_W+1:0]  req_end;
  logic [SECTOR_W+1:0]  bad_span;
  logic                 ent_skip, ent_hit, ent_pre;
  logic [COUNT_W-1:0]   pre_cnt, bad_cnt;
  logic [SECTOR_W-1:0]  bad_sector;
  logic [CNT_W-1:0]     idx_inc;
  logic                 at_end;
  logic                 table_full;
  logic                 bad_is_last;

  assign out_free   = !out_valid_r || out_ready;
  assign table_full = (cnt_r == CNT_W'(TABLE_ENTRIES));

  always_comb begin
    bs33        = {1'b0, rd_q.bad_first};
    be33        = {1'b0, rd_q.bad_end};
    req_end     = {1'b0, pos_r} + (SECTOR_W+2)'(left_r);
    ent_skip    = (rd_q.bad_end < rd_q.bad_first) || (pos_r > be33);
    ent_hit     = (req_end > {1'b0, bs33});
    ent_pre     = (pos_r < bs33);
    pre_cnt     = COUNT_W'(bs33 - pos_r);
    bad_span    = {1'b0, be33} - {1'b0, pos_r} + (SECTOR_W+2)'(1);
    bad_cnt     = (bad_span > (SECTOR_W+2)'(left_r)) ? left_r : bad_span[COUNT_W-1:0];
    bad_sector  = rd_q.alt_first + (pos_r[SECTOR_W-1:0] - rd_q.bad_first);
    bad_is_last = (left_r == bad_cnt);
    idx_inc     = idx_r + 1'b1;
    at_end      = (idx_inc == cnt_r);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid && out_free && q_op.cmd == CMD_REMAP &&
            q_op.sector_count != '0) begin
          state_nxt = (cnt_r == '0) ? ST_TAIL : ST_READ;
        end
      end
      ST_READ: state_nxt = ST_EVAL;
      ST_EVAL: begin
        if (ent_skip) begin
          state_nxt = at_end ? ST_TAIL : ST_READ;
        end else if (!ent_hit) begin
          state_nxt = ST_TAIL;
        end else if (out_free && !ent_pre) begin
          if (bad_is_last) state_nxt = ST_IDLE;
          else if (at_end) state_nxt = ST_TAIL;
          else             state_nxt = ST_READ;
        end
      end
      ST_TAIL: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and result selection
  always_comb begin
    pop       = 1'b0;
    wr_en     = 1'b0;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    pos_nxt   = pos_r;
    left_nxt  = left_r;
    emit      = 1'b0;
    em_sector = '0;
    em_count  = '0;
    em_remap  = 1'b0;
    em_last   = 1'b0;
    em_status = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid && out_free) begin
          pop = 1'b1;
          case (q_op.cmd)
            CMD_CLEAR: begin
              cnt_nxt = '0;
              emit    = 1'b1;
              em_last = 1'b1;
            end
            CMD_APPEND: begin
              emit    = 1'b1;
              em_last = 1'b1;
              if (table_full) begin
                em_status = 1'b1;
              end else begin
                wr_en   = 1'b1;
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            CMD_REMAP: begin
              pos_nxt  = {1'b0, q_op.start_sector};
              left_nxt = q_op.sector_count;
              idx_nxt  = '0;
              if (q_op.sector_count == '0) begin
                emit      = 1'b1;
                em_sector = q_op.start_sector;
                em_last   = 1'b1;
              end
            end
            default: pop = 1'b1;
          endcase
        end
      end
      ST_EVAL: begin
        if (ent_skip) begin
          idx_nxt = idx_inc;
        end else if (ent_hit && out_free) begin
          emit = 1'b1;
          if (ent_pre) begin
            // healthy stretch ahead of the bad range
            em_sector = pos_r[SECTOR_W-1:0];
            em_count  = pre_cnt;
            pos_nxt   = bs33;
            left_nxt  = left_r - pre_cnt;
          end else begin
            // bad stretch, mapped into the alternate area
            em_sector = bad_sector;
            em_count  = bad_cnt;
            em_remap  = 1'b1;
            em_last   = bad_is_last;
            pos_nxt   = pos_r + (SECTOR_W+1)'(bad_cnt);
            left_nxt  = left_r - bad_cnt;
            idx_nxt   = idx_inc;
          end
        end
      end
      ST_TAIL: begin
        if (out_free) begin
          emit      = 1'b1;
          em_sector = pos_r[SECTOR_W-1:0];
          em_count  = left_r;
          em_last   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (emit)           out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Walk and result payload registers
  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    pos_r  <= pos_nxt;
    left_r <= left_nxt;
    if (emit) begin
      out_sector_r <= em_sector;
      out_count_r  <= em_count;
      out_remap_r  <= em_remap;
      out_last_r   <= em_last;
      out_status_r <= em_status;
    end
  end

  // Table write on append, read one entry per walk step
  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[cnt_r[IDX_W-1:0]] <= '{bad_first: q_op.bad_first,
                                       bad_end:   q_op.bad_end,
                                       alt_first: q_op.alt_first};
    end
    if (state_r == ST_READ) begin
      rd_q <= table_mem[idx_r[IDX_W-1:0]];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_run_sector = out_sector_r;
  assign out_run_count  = out_count_r;
  assign out_remapped   = out_remap_r;
  assign out_last_run   = out_last_r;
  assign out_status     = out_status_r;
  assign entry_cnt      = cnt_r;

endmodule

@@ rtl/bad_sector_run_remapper.sv @@
// ----------------------------------------------------------------------------
// Bad-sector run remapper
// Keeps a table of bad-sector ranges and splits read requests into
// contiguous healthy and remapped runs.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready  | cmd, start, count, entry fields
//  out_    | output    | out_valid/out_ready  | run sector/count, flags, status
//
//  Clear, append and a zero-count request are done as they are popped and give one item.
//  A request is popped, then each table entry visited is read and then evaluated, and
//  a healthy run goes out before the bad run; the single table read port sets this order.
//  Reset empties the table and queue at once; no clearing pass is needed.
//  A stalled output holds the walk at its next run; the front keeps taking items until the
//  two-entry queue fills.
`include "bad_sector_run_remapper_defines.svh"

module bad_sector_run_remapper #(
  parameter int TABLE_ENTRIES = 64,
  parameter int MAX_REQUEST   = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_cmd,
  input  logic [bsrr_pkg::SECTOR_W-1:0] in_start_sector,
  input  logic [bsrr_pkg::COUNT_W-1:0]  in_sector_count,
  input  logic [bsrr_pkg::SECTOR_W-1:0] in_entry_bad_start,
  input  logic [bsrr_pkg::SECTOR_W-1:0] in_entry_bad_end,
  input  logic [bsrr_pkg::SECTOR_W-1:0] in_entry_good_start,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bsrr_pkg::SECTOR_W-1:0] out_run_sector,
  output logic [bsrr_pkg::COUNT_W-1:0]  out_run_count,
  output logic                          out_remapped,
  output logic                          out_last_run,
  output logic                          out_status
);
  import bsrr_pkg::*;

  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  logic             push;
  op_t              push_op;
  logic             q_room;
  logic             q_valid;
  op_t              q_op;
  logic             pop;
  logic [CNT_W-1:0] entry_cnt;

  bsrr_front #(
    .MAX_REQUEST(MAX_REQUEST)
  ) u_front (
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_cmd             (in_cmd),
    .in_start_sector    (in_start_sector),
    .in_sector_count    (in_sector_count),
    .in_entry_bad_start (in_entry_bad_start),
    .in_entry_bad_end   (in_entry_bad_end),
    .in_entry_good_start(in_entry_good_start),
    .push               (push),
    .push_op            (push_op),
    .q_room             (q_room)
  );

  bsrr_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .push_op(push_op),
    .q_room (q_room),
    .q_valid(q_valid),
    .q_op   (q_op),
    .pop    (pop)
  );

  bsrr_back #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .CNT_W        (CNT_W)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_op          (q_op),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_run_sector(out_run_sector),
    .out_run_count (out_run_count),
    .out_remapped  (out_remapped),
    .out_last_run  (out_last_run),
    .out_status    (out_status),
    .entry_cnt     (entry_cnt)
  );

  // Checks
  `BSRR_ASSERT_NOW(a_remap_nonempty, out_valid && out_remapped,
    out_run_count != '0, "remapped run with no sectors")
  `BSRR_ASSERT_NOW(a_full_is_ack, out_valid && out_status,
    out_last_run && !out_remapped && out_run_count == '0, "table-full status on a run")
  `BSRR_ASSERT_NOW(a_cnt_bound, 1'b1,
    entry_cnt <= CNT_W'(TABLE_ENTRIES), "entry count beyond table size")
  `BSRR_ASSERT_NXT(a_clear_empties, pop && q_op.cmd == CMD_CLEAR,
    entry_cnt == '0, "clear did not empty the table")

endmodule
